// ===== rtl/core/b377fp2_pkg.sv =====
// Package for the BLS12-377 Fp2 ALU: payload types, field constants and the
// sequencer microcode. Depends on nothing; used by every module of the block.
`default_nettype none
package b377fp2_pkg;

	localparam int LIMBS_PER_COORD = 6;
	localparam int LIMB_BITS       = 64;
	localparam int STORE_LIMBS     = 2 * LIMBS_PER_COORD;
	localparam int FP_BITS         = LIMBS_PER_COORD * LIMB_BITS;
	localparam int EXP_BITS        = 377;

	localparam logic [FP_BITS-1:0] MOD_P = {
		64'h01ae3a4617c510ea, 64'hc63b05c06ca1493b, 64'h1a22d9f300f5138f,
		64'h1ef3622fba094800, 64'h170b5d4430000000, 64'h8508c00000000001};
	localparam logic [FP_BITS-1:0] MONT_ONE = {
		64'h01660e3656e542d7, 64'hd6c3bc1926ff4de3, 64'h547f52db80ceae5c,
		64'h54894ed68a3d2a2e, 64'h5e941d24c60ba5e9, 64'h7d1c7fffffffd3b1};
	localparam logic [FP_BITS-1:0] EXP_PM2 = {
		64'h01ae3a4617c510ea, 64'hc63b05c06ca1493b, 64'h1a22d9f300f5138f,
		64'h1ef3622fba094800, 64'h170b5d4430000000, 64'h8508bfffffffffff};

	typedef enum logic [2:0] {
		ACT_ADD = 3'd0, ACT_SUB = 3'd1, ACT_NEG = 3'd2,
		ACT_MUL = 3'd3, ACT_SQR = 3'd4, ACT_INV = 3'd5
	} action_t;

	typedef struct packed {
		logic [2:0]           action;
		logic                 operand_select;
		logic [3:0]           limb_index;
		logic [LIMB_BITS-1:0] limb_value;
		logic                 start_compute;
	} req_t;

	typedef struct packed {
		logic [3:0]           result_index;
		logic [LIMB_BITS-1:0] result_limb;
		logic                 result_last;
		logic                 range_error;
	} rsp_t;

	typedef enum logic [2:0] {
		UOP_ADD, UOP_SUB, UOP_MUL, UOP_MULC, UOP_LOOP, UOP_END
	} uop_t;

	typedef enum logic [3:0] {
		R_XA, R_XB, R_YC, R_YD, R_T0, R_T1, R_T2, R_T3, R_T4, R_ZERO, R_ONE
	} reg_t;

	typedef struct packed {
		uop_t op;
		reg_t dst;
		reg_t s1;
		reg_t s2;
	} uinst_t;

	localparam logic [5:0] PC_ADD  = 6'd0;
	localparam logic [5:0] PC_SUB  = 6'd3;
	localparam logic [5:0] PC_NEG  = 6'd6;
	localparam logic [5:0] PC_MUL  = 6'd9;
	localparam logic [5:0] PC_INV  = 6'd21;
	localparam logic [5:0] PC_LOOP = 6'd28;

	function automatic uinst_t ucode(input logic [5:0] pc);
		uinst_t u;
		u = '{UOP_END, R_T0, R_ZERO, R_ZERO};
		case (pc)
			6'd0:  u = '{UOP_ADD, R_T0, R_XA, R_YC};
			6'd1:  u = '{UOP_ADD, R_T2, R_XB, R_YD};
			6'd3:  u = '{UOP_SUB, R_T0, R_XA, R_YC};
			6'd4:  u = '{UOP_SUB, R_T2, R_XB, R_YD};
			6'd6:  u = '{UOP_SUB, R_T0, R_ZERO, R_XA};
			6'd7:  u = '{UOP_SUB, R_T2, R_ZERO, R_XB};
			// Karatsuba: v0, v1, (a+b)(c+d) - v0 - v1, v0 - 5*v1
			6'd9:  u = '{UOP_MUL, R_T0, R_XA, R_YC};
			6'd10: u = '{UOP_MUL, R_T1, R_XB, R_YD};
			6'd11: u = '{UOP_ADD, R_T2, R_XA, R_XB};
			6'd12: u = '{UOP_ADD, R_T3, R_YC, R_YD};
			6'd13: u = '{UOP_MUL, R_T2, R_T2, R_T3};
			6'd14: u = '{UOP_SUB, R_T2, R_T2, R_T0};
			6'd15: u = '{UOP_SUB, R_T2, R_T2, R_T1};
			6'd16: u = '{UOP_ADD, R_T3, R_T1, R_T1};
			6'd17: u = '{UOP_ADD, R_T3, R_T3, R_T3};
			6'd18: u = '{UOP_ADD, R_T3, R_T3, R_T1};
			6'd19: u = '{UOP_SUB, R_T0, R_T0, R_T3};
			// inverse: norm, power p-2, scale (a,-b)
			6'd21: u = '{UOP_MUL, R_T0, R_XA, R_XA};
			6'd22: u = '{UOP_MUL, R_T1, R_XB, R_XB};
			6'd23: u = '{UOP_ADD, R_T3, R_T1, R_T1};
			6'd24: u = '{UOP_ADD, R_T3, R_T3, R_T3};
			6'd25: u = '{UOP_ADD, R_T3, R_T3, R_T1};
			6'd26: u = '{UOP_ADD, R_T4, R_T0, R_T3};
			6'd27: u = '{UOP_ADD, R_T1, R_ONE, R_ZERO};
			6'd28: u = '{UOP_MUL, R_T1, R_T1, R_T1};
			6'd29: u = '{UOP_MULC, R_T1, R_T1, R_T4};
			6'd30: u = '{UOP_LOOP, R_T1, R_ZERO, R_ZERO};
			6'd31: u = '{UOP_SUB, R_T3, R_ZERO, R_XB};
			6'd32: u = '{UOP_MUL, R_T0, R_XA, R_T1};
			6'd33: u = '{UOP_MUL, R_T2, R_T3, R_T1};
			default: u = '{UOP_END, R_T0, R_ZERO, R_ZERO};
		endcase
		return u;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/b377fp2_mont_mul.sv =====
// Bit-serial Montgomery multiplier, r = a*b/2^384 mod p, one bit of a a cycle.
// Depends on b377fp2_pkg.
`default_nettype none
module b377fp2_mont_mul
	import b377fp2_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [FP_BITS-1:0] a,
	input  wire logic [FP_BITS-1:0] b,
	output logic                    done,
	output logic [FP_BITS-1:0]      r
);
	localparam int TW = FP_BITS + 2;

	typedef enum logic [1:0] {M_IDLE, M_RUN, M_FIN} mstate_t;

	mstate_t            state_q;
	logic [8:0]         cnt_q;
	logic [FP_BITS-1:0] a_q, b_q;
	logic [TW-1:0]      t_q;
	logic [TW-1:0]      s1, s2, tsub;

	always_comb begin
		s1 = t_q + (a_q[0] ? {2'b00, b_q} : '0);
		s2 = s1 + (s1[0] ? {2'b00, MOD_P} : '0);
		tsub = t_q - {2'b00, MOD_P};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			cnt_q   <= '0;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				M_IDLE: begin
					if (start) begin
						a_q     <= a;
						b_q     <= b;
						t_q     <= '0;
						cnt_q   <= '0;
						state_q <= M_RUN;
					end
				end
				M_RUN: begin
					t_q   <= {1'b0, s2[TW-1:1]};
					a_q   <= {1'b0, a_q[FP_BITS-1:1]};
					cnt_q <= cnt_q + 9'd1;
					if (cnt_q == 9'(FP_BITS - 1))
						state_q <= M_FIN;
				end
				M_FIN: begin
					// t below 2p here: one conditional subtract
					r       <= tsub[TW-1] ? t_q[FP_BITS-1:0] : tsub[FP_BITS-1:0];
					done    <= 1'b1;
					state_q <= M_IDLE;
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/bls12_377_fp2_alu_core.sv =====
// Top level of the BLS12-377 Fp2 ALU: operand stores, microcoded sequencer,
// add/subtract unit and result streaming. Depends on b377fp2_pkg, b377fp2_mont_mul.
`default_nettype none
// Limbs load one transaction a cycle into the x or y store; the transaction
// with start_compute set runs the operation, and the block then takes no
// transaction until all twelve result limbs have gone out. Every product goes
// through one bit-serial Montgomery multiplier, and each add or subtract runs
// in the combinational add/subtract unit. The result goes out as twelve limb
// transactions. A coordinate not below p (y checked only for add, subtract
// and multiply) gives twelve zero limbs flagged.
module bls12_377_fp2_alu_core
	import b377fp2_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output rsp_t      rsp
);
	typedef enum logic [2:0] {S_IDLE, S_START, S_EXEC, S_WAIT, S_OUT} state_t;

	state_t               state_q;
	logic [LIMB_BITS-1:0] x_q [STORE_LIMBS];
	logic [LIMB_BITS-1:0] y_q [STORE_LIMBS];
	logic [FP_BITS-1:0]   t0_q, t1_q, t2_q, t3_q, t4_q;
	logic [5:0]           pc_q;
	logic [8:0]           exp_cnt_q;
	logic [2:0]           action_q;
	logic                 err_q, zero_q;
	logic [3:0]           oidx_q;

	logic [FP_BITS-1:0] xa, xb, yc, yd, op1, op2, addsub_r, mul_r;
	logic [FP_BITS:0]   sum, sred, dif;
	logic               mul_start, mul_done, exp_bit;
	logic [8:0]         exp_pos;
	uinst_t             ui;

	always_comb begin
		for (int i = 0; i < LIMBS_PER_COORD; i++) begin
			xa[i*LIMB_BITS +: LIMB_BITS] = x_q[i];
			xb[i*LIMB_BITS +: LIMB_BITS] = x_q[i + LIMBS_PER_COORD];
			yc[i*LIMB_BITS +: LIMB_BITS] = y_q[i];
			yd[i*LIMB_BITS +: LIMB_BITS] = y_q[i + LIMBS_PER_COORD];
		end
	end

	function automatic logic [FP_BITS-1:0] pick(input reg_t s,
			input logic [FP_BITS-1:0] pa, pb, pc, pd, r0, r1, r2, r3, r4,
			input logic sq);
		logic [FP_BITS-1:0] v;
		case (s)
			R_XA:    v = pa;
			R_XB:    v = pb;
			R_YC:    v = sq ? pa : pc;   // square reuses x as second operand
			R_YD:    v = sq ? pb : pd;
			R_T0:    v = r0;
			R_T1:    v = r1;
			R_T2:    v = r2;
			R_T3:    v = r3;
			R_T4:    v = r4;
			R_ONE:   v = MONT_ONE;
			default: v = '0;
		endcase
		return v;
	endfunction

	assign ui      = ucode(pc_q);
	assign exp_pos = 9'(EXP_BITS - 1) - exp_cnt_q;
	assign exp_bit = EXP_PM2[exp_pos];

	always_comb begin
		op1 = pick(ui.s1, xa, xb, yc, yd, t0_q, t1_q, t2_q, t3_q, t4_q,
			action_q == ACT_SQR);
		op2 = pick(ui.s2, xa, xb, yc, yd, t0_q, t1_q, t2_q, t3_q, t4_q,
			action_q == ACT_SQR);
		sum  = {1'b0, op1} + {1'b0, op2};
		sred = sum - {1'b0, MOD_P};
		dif  = {1'b0, op1} - {1'b0, op2};
		if (ui.op == UOP_SUB)
			addsub_r = dif[FP_BITS] ? dif[FP_BITS-1:0] + MOD_P : dif[FP_BITS-1:0];
		else
			addsub_r = sred[FP_BITS] ? sum[FP_BITS-1:0] : sred[FP_BITS-1:0];
	end

	assign mul_start = (state_q == S_EXEC) &&
		((ui.op == UOP_MUL) || ((ui.op == UOP_MULC) && exp_bit));

	b377fp2_mont_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (op1),
		.b      (op2),
		.done   (mul_done),
		.r      (mul_r)
	);

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = (state_q == S_OUT);

	always_comb begin
		logic [2*FP_BITS-1:0] res;
		res = {t2_q, t0_q};
		rsp.result_index = oidx_q;
		rsp.result_limb  = zero_q ? '0 : res[oidx_q*LIMB_BITS +: LIMB_BITS];
		rsp.result_last  = (oidx_q == 4'(STORE_LIMBS - 1));
		rsp.range_error  = err_q;
	end

	// stores: one write per load transaction with limb_index below 12, whole coordinates read at fixed places
	always_ff @(posedge clk) begin
		if (req_valid && req_ready && (req.limb_index < 4'(STORE_LIMBS))) begin
			if (req.operand_select)
				y_q[req.limb_index] <= req.limb_value;
			else
				x_q[req.limb_index] <= req.limb_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			pc_q      <= '0;
			exp_cnt_q <= '0;
			oidx_q    <= '0;
			err_q     <= 1'b0;
			zero_q    <= 1'b0;
			action_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid && req.start_compute) begin
						action_q <= req.action;
						state_q  <= S_START;
					end
				end
				S_START: begin
					oidx_q <= '0;
					err_q  <= 1'b0;
					zero_q <= 1'b0;
					state_q <= S_EXEC;
					case (action_q)
						ACT_ADD: pc_q <= PC_ADD;
						ACT_SUB: pc_q <= PC_SUB;
						ACT_NEG: pc_q <= PC_NEG;
						ACT_MUL, ACT_SQR: pc_q <= PC_MUL;
						ACT_INV: pc_q <= PC_INV;
						default: begin
							zero_q  <= 1'b1;
							state_q <= S_OUT;
						end
					endcase
					if (action_q <= ACT_INV) begin
						if ((xa >= MOD_P) || (xb >= MOD_P) ||
								(((action_q == ACT_ADD) || (action_q == ACT_SUB) ||
								(action_q == ACT_MUL)) && ((yc >= MOD_P) || (yd >= MOD_P)))) begin
							err_q   <= 1'b1;
							zero_q  <= 1'b1;
							state_q <= S_OUT;
						end
					end
				end
				S_EXEC: begin
					case (ui.op)
						UOP_ADD, UOP_SUB: begin
							case (ui.dst)
								R_T0:    t0_q <= addsub_r;
								R_T1:    t1_q <= addsub_r;
								R_T2:    t2_q <= addsub_r;
								R_T3:    t3_q <= addsub_r;
								default: t4_q <= addsub_r;
							endcase
							pc_q <= pc_q + 6'd1;
						end
						UOP_MUL: state_q <= S_WAIT;
						UOP_MULC: begin
							if (exp_bit) state_q <= S_WAIT;
							else pc_q <= pc_q + 6'd1;
						end
						UOP_LOOP: begin
							if (exp_cnt_q == 9'(EXP_BITS - 1)) begin
								exp_cnt_q <= '0;
								pc_q      <= pc_q + 6'd1;
							end else begin
								exp_cnt_q <= exp_cnt_q + 9'd1;
								pc_q      <= PC_LOOP;
							end
						end
						default: state_q <= S_OUT;
					endcase
				end
				S_WAIT: begin
					if (mul_done) begin
						case (ui.dst)
							R_T0:    t0_q <= mul_r;
							R_T1:    t1_q <= mul_r;
							R_T2:    t2_q <= mul_r;
							R_T3:    t3_q <= mul_r;
							default: t4_q <= mul_r;
						endcase
						pc_q    <= pc_q + 6'd1;
						state_q <= S_EXEC;
					end
				end
				S_OUT: begin
					if (rsp_ready) begin
						oidx_q <= oidx_q + 4'd1;
						if (oidx_q == 4'(STORE_LIMBS - 1))
							state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(req_ready && rsp_valid)) else $error("ready while results pending");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.range_error) |-> (rsp.result_limb == '0))
		else $error("flagged result not zero");
	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.result_last) |-> (rsp.result_index == 4'd11))
		else $error("last flag on wrong limb");
	a_mul_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == S_WAIT)) else $error("product with no waiter");
	a_start_exec: assert property (@(posedge clk) disable iff (!arst_n)
		mul_start |=> (state_q == S_WAIT)) else $error("product not awaited");

endmodule
`default_nettype wire
